@@ rtl/lpfp_pkg.sv @@
// Package for the length-prefixed frame parser.
// Holds payload and register types, register indexes, status codes and reset values.
// No dependencies; every other file of the block uses it.
package lpfp_pkg;

  localparam int unsigned HdrBytes  = 12;
  localparam int unsigned JlenBytes = 4;
  localparam int unsigned CntW      = 4;

  localparam logic [1:0] CFG_MAGIC   = 2'd0;
  localparam logic [1:0] CFG_VERSION = 2'd1;
  localparam logic [1:0] CFG_MAX_LEN = 2'd2;
  localparam logic [1:0] CFG_RAW_MSK = 2'd3;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_MAGIC = 3'd1;
  localparam logic [2:0] ST_BAD_VER   = 3'd2;
  localparam logic [2:0] ST_TOO_LARGE = 3'd3;
  localparam logic [2:0] ST_NO_JLEN   = 3'd4;
  localparam logic [2:0] ST_JLEN_OVF  = 3'd5;

  localparam logic [31:0] MagicRst   = 32'd0;
  localparam logic [7:0]  VersionRst = 8'd1;
  localparam logic [31:0] MaxLenRst  = 32'd16777216;
  localparam logic [15:0] RawMskRst  = 16'd1;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       restart;
  } in_t;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        data_valid;
    logic        is_raw;
    logic [7:0]  msg_type;
    logic [15:0] frame_flags;
    logic [31:0] body_length;
    logic [2:0]  status;
    logic        frame_end;
  } out_t;

  typedef struct packed {
    logic [1:0]  index;
    logic [31:0] value;
  } cfg_wr_t;

  typedef struct packed {
    logic [31:0] magic_word;
    logic [7:0]  protocol_version;
    logic [31:0] max_body_length;
    logic [15:0] raw_flag_mask;
  } cfg_t;

endpackage

@@ rtl/lpfp_if.sv @@
// Valid/ready channel interfaces of the length-prefixed frame parser.
// Depends on lpfp_pkg for the payload types.
interface lpfp_in_if;
  logic         valid;
  logic         ready;
  lpfp_pkg::in_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface lpfp_out_if;
  logic          valid;
  logic          ready;
  lpfp_pkg::out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface lpfp_cfg_if;
  logic             valid;
  logic             ready;
  lpfp_pkg::cfg_wr_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/lpfp_core.sv @@
// Parser state and per-byte next-state and result logic.
// Depends on lpfp_pkg.
module lpfp_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            accept_i,
  input  lpfp_pkg::in_t   in_i,
  input  lpfp_pkg::cfg_t  cfg_i,
  output logic            res_valid_o,
  output lpfp_pkg::out_t  res_o
);

  localparam logic [1:0] PH_HEADER  = 2'd0;
  localparam logic [1:0] PH_JLEN    = 2'd1;
  localparam logic [1:0] PH_BODY    = 2'd2;
  localparam logic [1:0] PH_DISCARD = 2'd3;

  localparam logic [lpfp_pkg::CntW-1:0] HdrLast  = lpfp_pkg::CntW'(lpfp_pkg::HdrBytes - 1);
  localparam logic [lpfp_pkg::CntW-1:0] JlenLast = lpfp_pkg::CntW'(lpfp_pkg::JlenBytes - 1);
  localparam logic [31:0] JlenBytes32 = 32'(lpfp_pkg::JlenBytes);

  logic [1:0]                phase_q, phase_d, phase_v;
  logic [lpfp_pkg::CntW-1:0] cnt_q, cnt_d, cnt_v;
  logic [31:0]               magic_q, magic_d;
  logic [7:0]                version_q, version_d;
  logic [7:0]                type_q, type_d;
  logic [15:0]               flags_q, flags_d;
  logic [31:0]               length_q, length_d;
  logic [31:0]               json_q, json_d;
  logic [31:0]               body_q, body_d;
  logic [7:0]                b;
  logic                      fail;
  logic [2:0]                fail_st;

  assign b = in_i.in_byte;

  always_comb begin
    phase_v     = in_i.restart ? PH_HEADER : phase_q;
    cnt_v       = in_i.restart ? '0 : cnt_q;
    phase_d     = phase_v;
    cnt_d       = cnt_v;
    magic_d     = magic_q;
    version_d   = version_q;
    type_d      = type_q;
    flags_d     = flags_q;
    length_d    = length_q;
    json_d      = json_q;
    body_d      = body_q;
    fail        = 1'b0;
    fail_st     = lpfp_pkg::ST_OK;
    res_valid_o = 1'b0;
    res_o       = '0;
    case (phase_v)
      PH_HEADER: begin
        if (cnt_v < 4'd4) begin
          magic_d = {magic_q[23:0], b};
        end else if (cnt_v == 4'd4) begin
          version_d = b;
        end else if (cnt_v == 4'd5) begin
          type_d = b;
        end else if (cnt_v < 4'd8) begin
          flags_d = {flags_q[7:0], b};
        end else begin
          length_d = {length_q[23:0], b};
        end
        if (cnt_v != HdrLast) begin
          cnt_d = cnt_v + 1'b1;
        end else begin
          cnt_d = '0;
          if (magic_d != cfg_i.magic_word) begin
            fail    = 1'b1;
            fail_st = lpfp_pkg::ST_BAD_MAGIC;
          end else if (version_d != cfg_i.protocol_version) begin
            fail    = 1'b1;
            fail_st = lpfp_pkg::ST_BAD_VER;
          end else if (length_d > cfg_i.max_body_length) begin
            fail    = 1'b1;
            fail_st = lpfp_pkg::ST_TOO_LARGE;
          end else if ((flags_d & cfg_i.raw_flag_mask) != 16'd0) begin
            if (length_d < JlenBytes32) begin
              fail    = 1'b1;
              fail_st = lpfp_pkg::ST_NO_JLEN;
            end else begin
              phase_d = PH_JLEN;
              json_d  = '0;
            end
          end else if (length_d == 32'd0) begin
            phase_d         = PH_HEADER;
            res_valid_o     = 1'b1;
            res_o.frame_end = 1'b1;
          end else begin
            json_d  = length_d;
            body_d  = length_d;
            phase_d = PH_BODY;
          end
        end
      end
      PH_JLEN: begin
        json_d = {json_q[23:0], b};
        if (cnt_v != JlenLast) begin
          cnt_d = cnt_v + 1'b1;
        end else begin
          cnt_d = '0;
          if (({1'b0, json_d} + {1'b0, JlenBytes32}) > {1'b0, length_q}) begin
            fail    = 1'b1;
            fail_st = lpfp_pkg::ST_JLEN_OVF;
          end else begin
            body_d = length_q - JlenBytes32;
            if (length_q == JlenBytes32) begin
              phase_d         = PH_HEADER;
              res_valid_o     = 1'b1;
              res_o.frame_end = 1'b1;
            end else begin
              phase_d = PH_BODY;
            end
          end
        end
      end
      PH_BODY: begin
        if (json_q != 32'd0) begin
          json_d = json_q - 32'd1;
        end
        if (body_q != 32'd0) begin
          body_d = body_q - 32'd1;
        end
        res_valid_o      = 1'b1;
        res_o.data_byte  = b;
        res_o.data_valid = 1'b1;
        res_o.is_raw     = (json_q == 32'd0);
        res_o.frame_end  = (body_d == 32'd0);
        if (body_d == 32'd0) begin
          phase_d = PH_HEADER;
          cnt_d   = '0;
        end
      end
      default: begin
      end
    endcase
    if (fail) begin
      phase_d         = PH_DISCARD;
      cnt_d           = '0;
      res_valid_o     = 1'b1;
      res_o.status    = fail_st;
      res_o.frame_end = 1'b1;
    end
    res_o.msg_type    = type_d;
    res_o.frame_flags = flags_d;
    res_o.body_length = length_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_HEADER;
      cnt_q     <= '0;
      magic_q   <= '0;
      version_q <= '0;
      type_q    <= '0;
      flags_q   <= '0;
      length_q  <= '0;
      json_q    <= '0;
      body_q    <= '0;
    end else if (accept_i) begin
      phase_q   <= phase_d;
      cnt_q     <= cnt_d;
      magic_q   <= magic_d;
      version_q <= version_d;
      type_q    <= type_d;
      flags_q   <= flags_d;
      length_q  <= length_d;
      json_q    <= json_d;
      body_q    <= body_d;
    end
  end

  a_discard_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_DISCARD && accept_i && !in_i.restart) |=> (phase_q == PH_DISCARD))
    else $error("discard phase left without restart");

  a_jlen_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_JLEN) |-> (cnt_q <= JlenLast))
    else $error("JSON length byte count out of range");

  a_body_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_BODY) |-> (body_q != 32'd0))
    else $error("body phase with no bytes left");

  a_data_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && res_valid_o && res_o.status != lpfp_pkg::ST_OK) |=> (phase_q == PH_DISCARD))
    else $error("error result without entering discard phase");

endmodule

@@ rtl/lpfp_skid.sv @@
// Two-entry output register with skid stage for result beats.
// Depends on lpfp_pkg for the result type.
module lpfp_skid (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  input  lpfp_pkg::out_t data_i,
  output logic           ready_o,
  output logic           valid_o,
  output lpfp_pkg::out_t data_o,
  input  logic           ready_i
);

  logic           main_valid_q;
  lpfp_pkg::out_t main_data_q;
  logic           skid_valid_q;
  lpfp_pkg::out_t skid_data_q;

  assign ready_o = !skid_valid_q;
  assign valid_o = main_valid_q;
  assign data_o  = main_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (ready_i || !main_valid_q) begin
      if (skid_valid_q) begin
        main_valid_q <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        main_valid_q <= valid_i;
      end
    end else if (valid_i) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_i || !main_valid_q) begin
      if (skid_valid_q) begin
        main_data_q <= skid_data_q;
      end else begin
        main_data_q <= data_i;
      end
    end else if (valid_i && !skid_valid_q) begin
      skid_data_q <= data_i;
    end
  end

  a_skid_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> main_valid_q)
    else $error("skid entry held while output register is empty");

endmodule

@@ rtl/length_prefixed_frame_parser.sv @@
// Top level of the length-prefixed frame parser: register bank, parser core, output stage.
// Depends on lpfp_pkg, the channel interfaces, lpfp_core and lpfp_skid.
//
// The input channel carries one stream byte per beat, with a restart bit that returns
// the parser to header start before that byte. Each frame has a 12-byte big-endian
// header (magic, version, type, flags, body length) and, for raw frames, a 4-byte
// JSON length. Body bytes leave on the output channel tagged as JSON or raw; a
// result with frame_end set closes a frame or reports an error, after which bytes
// are dropped until restart. Header bytes normally give no output beat.
// The configuration channel writes magic word, version, maximum body length and
// raw flag mask by index and is always ready; the user must write it only while idle, as the block does not enforce it.
// One byte is accepted per cycle while input ready is high; its result is registered in
// the output register behind the parser logic before it appears on the output.
// Reset puts the parser at header start and loads the register reset values.
// When the receiver stalls, one further result is held in a skid stage; input
// ready drops only while that stage is occupied.
module length_prefixed_frame_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  lpfp_in_if.sink     in_i,
  lpfp_out_if.source  out_o,
  lpfp_cfg_if.sink    cfg_i
);

  lpfp_pkg::cfg_t cfg_q;
  lpfp_pkg::out_t res;
  logic           res_valid;
  logic           accept;
  logic           res_ready;

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = res_ready;
  assign accept      = in_i.valid && res_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.magic_word       <= lpfp_pkg::MagicRst;
      cfg_q.protocol_version <= lpfp_pkg::VersionRst;
      cfg_q.max_body_length  <= lpfp_pkg::MaxLenRst;
      cfg_q.raw_flag_mask    <= lpfp_pkg::RawMskRst;
    end else if (cfg_i.valid) begin
      case (cfg_i.data.index)
        lpfp_pkg::CFG_MAGIC:   cfg_q.magic_word       <= cfg_i.data.value;
        lpfp_pkg::CFG_VERSION: cfg_q.protocol_version <= cfg_i.data.value[7:0];
        lpfp_pkg::CFG_MAX_LEN: cfg_q.max_body_length  <= cfg_i.data.value;
        lpfp_pkg::CFG_RAW_MSK: cfg_q.raw_flag_mask    <= cfg_i.data.value[15:0];
        default: begin
        end
      endcase
    end
  end

  lpfp_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .in_i        (in_i.data),
    .cfg_i       (cfg_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  lpfp_skid u_skid (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (accept && res_valid),
    .data_i  (res),
    .ready_o (res_ready),
    .valid_o (out_o.valid),
    .data_o  (out_o.data),
    .ready_i (out_o.ready)
  );

endmodule
